[rtl/swerve_inverse_kinematics_defines.svh]
// Assertion macros shared by the swerve kinematics RTL.
`ifndef SWERVE_INVERSE_KINEMATICS_DEFINES_SVH
`define SWERVE_INVERSE_KINEMATICS_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SIK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define SIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sik_pkg.sv]
`default_nettype none

package sik_pkg;

    // Sizes
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int NUM_WHEELS       = 4;

    localparam int VEL_W      = 15;
    localparam int YAW_W      = 16;
    localparam int RAD_W      = 10;
    localparam int DIST_W     = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int SPEED_W    = 20;
    localparam int ANGLE_W    = 16;
    localparam int ACC_W      = 32;

    // Internal datapath widths
    localparam int TRANS_W = 41;   // vel * 1000 * 2^16
    localparam int WD_W    = 28;   // yaw * dist
    localparam int ROT_W   = 43;   // yaw * dist * 46341
    localparam int VEC_W   = 44;   // wheel vector before CORDIC
    localparam int CW      = 46;   // CORDIC x/y with gain growth

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_DIST  = 2'd1;
    localparam logic [RAD_W-1:0]      RADIUS_RESET     = 10'd76;
    localparam logic [DIST_W-1:0]     DIST_RESET       = 11'd300;

    // Constants
    localparam logic [16:0]  HALF_ROOT2_Q16 = 17'd46341;
    localparam logic [15:0]  GAIN_INV_Q16   = 16'd39797;
    localparam logic [10:0]  MM_PER_M       = 11'd1000;
    localparam logic [1:0]   WHEEL_FIRST    = 2'd0;
    localparam logic [1:0]   WHEEL_LAST     = 2'd3;
    localparam logic [1:0]   WHEEL_FL       = 2'd0;
    localparam logic [1:0]   WHEEL_RL       = 2'd1;
    localparam logic [1:0]   WHEEL_RR       = 2'd2;
    localparam logic [1:0]   WHEEL_FR       = 2'd3;
    // Tangent sign per wheel, bit k set means negative
    localparam logic [3:0]   SX_NEG         = 4'b0011;
    localparam logic [3:0]   SY_NEG         = 4'b0110;

    // One queued velocity command
    typedef struct packed {
        logic signed [TRANS_W-1:0] tx;
        logic signed [TRANS_W-1:0] ty;
        logic signed [ROT_W-1:0]   rot;
    } cmd_t;

    // Per-wheel tag carried down the back pipeline
    typedef struct packed {
        logic       zero;
        logic [1:0] wheel;
    } tag_t;

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic [ACC_W-1:0] atan_turn(input int unsigned idx);
        logic [ACC_W-1:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41721;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/sik_fifo.sv]
`default_nettype none

module sik_fifo #(
    parameter int DEPTH = sik_pkg::QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire sik_pkg::cmd_t                din,
    input  wire logic                         pop,
    output sik_pkg::cmd_t                     dout,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        level
);

    `include "swerve_inverse_kinematics_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    sik_pkg::cmd_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   count_reg, count_next;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

    `SIK_ASSERT_SAME(a_no_overflow, push && !pop, count_reg != LVL_W'(DEPTH),
        "queue written while full")
    `SIK_ASSERT_SAME(a_no_underflow, pop, count_reg != '0,
        "queue read while empty")

endmodule

`default_nettype wire

[rtl/sik_front.sv]
`default_nettype none

module sik_front #(
    parameter int DEPTH = sik_pkg::QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [sik_pkg::VEL_W-1:0]    vel_fwd_mm_s,
    input  wire logic signed [sik_pkg::VEL_W-1:0]    vel_left_mm_s,
    input  wire logic signed [sik_pkg::YAW_W-1:0]    yaw_rate_mrad_s,
    input  wire logic [sik_pkg::DIST_W-1:0]          center_to_wheel_mm,
    input  wire logic [$clog2(DEPTH+1)-1:0]          queue_level,
    output logic                                     push,
    output sik_pkg::cmd_t                            cmd
);

    localparam int LVL_W = $clog2(DEPTH+1);

    logic                                   accept;
    logic [LVL_W:0]                         occupancy;
    logic signed [sik_pkg::TRANS_W-1:0]     tx_scaled, ty_scaled;
    logic signed [sik_pkg::WD_W-1:0]        wd_prod;
    logic signed [sik_pkg::ROT_W-1:0]       rot_prod;

    logic                                   v1_reg, v2_reg;
    logic signed [sik_pkg::TRANS_W-1:0]     tx1_reg, ty1_reg, tx2_reg, ty2_reg;
    logic signed [sik_pkg::WD_W-1:0]        wd1_reg;
    logic signed [sik_pkg::ROT_W-1:0]       rot2_reg;

    // Hold off while queue plus words in flight could fill it
    assign occupancy = (LVL_W+1)'(queue_level) + (LVL_W+1)'(v1_reg) + (LVL_W+1)'(v2_reg);
    assign busy      = occupancy >= (LVL_W+1)'(DEPTH);
    assign accept    = start && !busy;

    // Scale translation to mm/s * 1000 * 2^16 and form yaw * distance
    assign tx_scaled = (sik_pkg::TRANS_W'(vel_fwd_mm_s)
                        * sik_pkg::TRANS_W'($signed({1'b0, sik_pkg::MM_PER_M}))) <<< 16;
    assign ty_scaled = (sik_pkg::TRANS_W'(vel_left_mm_s)
                        * sik_pkg::TRANS_W'($signed({1'b0, sik_pkg::MM_PER_M}))) <<< 16;
    assign wd_prod   = sik_pkg::WD_W'(yaw_rate_mrad_s)
                        * sik_pkg::WD_W'($signed({1'b0, center_to_wheel_mm}));

    // Apply the half root two tangent factor
    assign rot_prod  = sik_pkg::ROT_W'(wd1_reg)
                        * sik_pkg::ROT_W'($signed({1'b0, sik_pkg::HALF_ROOT2_Q16}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tx1_reg  <= tx_scaled;
        ty1_reg  <= ty_scaled;
        wd1_reg  <= wd_prod;
        tx2_reg  <= tx1_reg;
        ty2_reg  <= ty1_reg;
        rot2_reg <= rot_prod;
    end

    assign push    = v2_reg;
    assign cmd.tx  = tx2_reg;
    assign cmd.ty  = ty2_reg;
    assign cmd.rot = rot2_reg;

endmodule

`default_nettype wire

[rtl/sik_cordic.sv]
`default_nettype none

module sik_cordic #(
    parameter int STEPS = sik_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic signed [sik_pkg::VEC_W-1:0]      in_x,
    input  wire logic signed [sik_pkg::VEC_W-1:0]      in_y,
    input  wire logic [1:0]                            in_wheel,
    output logic                                       out_valid,
    output logic signed [sik_pkg::CW-1:0]              out_x,
    output logic [sik_pkg::ANGLE_W-1:0]                out_angle,
    output sik_pkg::tag_t                              out_tag
);

    localparam int CW    = sik_pkg::CW;
    localparam int ACC_W = sik_pkg::ACC_W;

    logic                   v_reg   [STEPS+1];
    logic signed [CW-1:0]   x_reg   [STEPS+1];
    logic signed [CW-1:0]   y_reg   [STEPS+1];
    logic [ACC_W-1:0]       acc_reg [STEPS+1];
    sik_pkg::tag_t          tag_reg [STEPS+1];

    logic signed [CW-1:0]   x_ext, y_ext;
    logic [ACC_W-1:0]       acc_round;

    assign x_ext = CW'(in_x);
    assign y_ext = CW'(in_y);

    // Fold the left half plane over and flag the zero vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0].wheel <= in_wheel;
        tag_reg[0].zero  <= (in_x == '0) && (in_y == '0);
        if (in_x < 0)
        begin
            x_reg[0]   <= -x_ext;
            y_reg[0]   <= -y_ext;
            acc_reg[0] <= {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            x_reg[0]   <= x_ext;
            y_reg[0]   <= y_ext;
            acc_reg[0] <= '0;
        end
    end

    // One vectoring step per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i+1] <= tag_reg[i];
            if (y_reg[i] < 0)
            begin
                x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] - sik_pkg::atan_turn(i);
            end
            else
            begin
                x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] + sik_pkg::atan_turn(i);
            end
        end
    end

    // Round the angle half up to 16 bits
    assign acc_round = acc_reg[STEPS] + ACC_W'(32'h8000);
    assign out_valid = v_reg[STEPS];
    assign out_x     = x_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];
    assign out_angle = tag_reg[STEPS].zero ? '0 : acc_round[ACC_W-1 -: sik_pkg::ANGLE_W];

endmodule

`default_nettype wire

[rtl/sik_back.sv]
`default_nettype none

module sik_back #(
    parameter int STEPS = sik_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_empty,
    input  wire sik_pkg::cmd_t                        q_cmd,
    output logic                                      q_pop,
    input  wire logic [sik_pkg::RAD_W-1:0]            wheel_radius_mm,
    output logic                                      done,
    output logic [sik_pkg::SPEED_W-1:0]               front_left_speed,
    output logic [sik_pkg::SPEED_W-1:0]               rear_left_speed,
    output logic [sik_pkg::SPEED_W-1:0]               rear_right_speed,
    output logic [sik_pkg::SPEED_W-1:0]               front_right_speed,
    output logic signed [sik_pkg::ANGLE_W-1:0]        front_left_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        rear_left_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        rear_right_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        front_right_angle
);

    `include "swerve_inverse_kinematics_defines.svh"

    localparam int VEC_W   = sik_pkg::VEC_W;
    localparam int CW      = sik_pkg::CW;
    localparam int XU_W    = CW - 1;
    localparam int SPLIT   = 22;
    localparam int HI_W    = XU_W - SPLIT;
    localparam int PLO_W   = SPLIT + 16;
    localparam int PHI_W   = HI_W + 16;
    localparam int PROD_W  = XU_W + 16;
    localparam int FRAC    = 24;
    localparam int N_W     = PROD_W - FRAC + 1;
    localparam int DV_W    = 20;
    localparam int QB      = sik_pkg::SPEED_W;
    localparam int RW      = DV_W + QB;
    localparam int AW      = sik_pkg::ANGLE_W;
    localparam int RAD_W_L = sik_pkg::RAD_W;

    // Issue sequencer
    logic                    active_reg;
    logic [1:0]              wheel_reg;
    sik_pkg::cmd_t           item_reg;

    // Wheel vector stage
    logic                    vec_v_reg;
    logic signed [VEC_W-1:0] nx_reg, ny_reg;
    logic [1:0]              vec_wheel_reg;
    logic signed [VEC_W-1:0] rot_ext, nx_next, ny_next;

    // CORDIC result
    logic                    cr_valid;
    logic signed [CW-1:0]    cr_x;
    logic [AW-1:0]           cr_angle;
    sik_pkg::tag_t           cr_tag;

    // Gain multiply and rounding stages
    logic [XU_W-1:0]         x_clamp;
    logic                    m_v_reg;
    logic [PLO_W-1:0]        plo_reg;
    logic [PHI_W-1:0]        phi_reg;
    logic [AW-1:0]           m_angle_reg;
    sik_pkg::tag_t           m_tag_reg;
    logic [RAD_W_L-1:0]      r_eff;
    logic [DV_W-1:0]         dv;
    logic [PROD_W-1:0]       bias, prod_sum;
    logic [N_W-1:0]          n_val;

    // Divider stages
    logic                    d_v_reg   [QB+1];
    logic [RW-1:0]           rem_reg   [QB+1];
    logic [QB-1:0]           q_reg     [QB+1];
    logic                    sat_reg   [QB+1];
    logic [AW-1:0]           angle_reg [QB+1];
    sik_pkg::tag_t           tag_reg   [QB+1];

    logic [sik_pkg::SPEED_W-1:0] fin_speed;
    logic                        fin_valid;
    logic [1:0]                  fin_wheel;

    logic                        done_reg;
    logic [sik_pkg::SPEED_W-1:0] spd_reg [sik_pkg::NUM_WHEELS];
    logic [AW-1:0]               ang_reg [sik_pkg::NUM_WHEELS];

    // Take the next command when idle or as the last wheel of the current one issues
    assign q_pop = !q_empty && (!active_reg || (wheel_reg == sik_pkg::WHEEL_LAST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wheel_reg  <= sik_pkg::WHEEL_FIRST;
        end
        else if (q_pop)
        begin
            active_reg <= 1'b1;
            wheel_reg  <= sik_pkg::WHEEL_FIRST;
        end
        else if (active_reg)
        begin
            if (wheel_reg == sik_pkg::WHEEL_LAST)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                wheel_reg <= wheel_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_cmd;
        end
    end

    // Form the wheel vector from translation and signed rotation
    assign rot_ext = VEC_W'(item_reg.rot);
    assign nx_next = VEC_W'(item_reg.tx) + (sik_pkg::SX_NEG[wheel_reg] ? -rot_ext : rot_ext);
    assign ny_next = VEC_W'(item_reg.ty) + (sik_pkg::SY_NEG[wheel_reg] ? -rot_ext : rot_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_v_reg <= 1'b0;
        end
        else
        begin
            vec_v_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        vec_wheel_reg <= wheel_reg;
    end

    sik_cordic #(
        .STEPS (STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_v_reg),
        .in_x      (nx_reg),
        .in_y      (ny_reg),
        .in_wheel  (vec_wheel_reg),
        .out_valid (cr_valid),
        .out_x     (cr_x),
        .out_angle (cr_angle),
        .out_tag   (cr_tag)
    );

    // Clamp negative x and multiply by the inverse gain in two halves
    assign x_clamp = (cr_x < 0) ? '0 : cr_x[XU_W-1:0];

    // Divisor is 1000 * R, rounding bias is 500 * R * 2^24
    assign r_eff    = (wheel_radius_mm == '0) ? RAD_W_L'(1) : wheel_radius_mm;
    assign dv       = DV_W'(r_eff) * DV_W'(sik_pkg::MM_PER_M);
    assign bias     = PROD_W'(dv) << (FRAC - 1);
    assign prod_sum = (PROD_W'(phi_reg) << SPLIT) + PROD_W'(plo_reg) + bias;
    assign n_val    = N_W'(prod_sum >> FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else
        begin
            m_v_reg <= cr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg     <= PLO_W'(x_clamp[SPLIT-1:0]) * PLO_W'(sik_pkg::GAIN_INV_Q16);
        phi_reg     <= PHI_W'(x_clamp[XU_W-1:SPLIT]) * PHI_W'(sik_pkg::GAIN_INV_Q16);
        m_angle_reg <= cr_angle;
        m_tag_reg   <= cr_tag;
    end

    // Load the divider and flag quotients that overflow the speed field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg[0] <= 1'b0;
        end
        else
        begin
            d_v_reg[0] <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]   <= RW'(n_val);
        q_reg[0]     <= '0;
        sat_reg[0]   <= (RW'(n_val) >= (RW'(dv) << QB));
        angle_reg[0] <= m_angle_reg;
        tag_reg[0]   <= m_tag_reg;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int B = QB - 1 - j;
        logic [RW-1:0] trial;
        assign trial = RW'(dv) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v_reg[j+1] <= 1'b0;
            end
            else
            begin
                d_v_reg[j+1] <= d_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sat_reg[j+1]   <= sat_reg[j];
            angle_reg[j+1] <= angle_reg[j];
            tag_reg[j+1]   <= tag_reg[j];
            if (rem_reg[j] >= trial)
            begin
                rem_reg[j+1] <= rem_reg[j] - trial;
                q_reg[j+1]   <= q_reg[j] | (QB'(1) << B);
            end
            else
            begin
                rem_reg[j+1] <= rem_reg[j];
                q_reg[j+1]   <= q_reg[j];
            end
        end
    end

    assign fin_valid = d_v_reg[QB];
    assign fin_wheel = tag_reg[QB].wheel;
    assign fin_speed = sat_reg[QB] ? {sik_pkg::SPEED_W{1'b1}} : q_reg[QB];

    // Gather the four wheels and strobe on the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_valid && (fin_wheel == sik_pkg::WHEEL_LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid)
        begin
            spd_reg[fin_wheel] <= fin_speed;
            ang_reg[fin_wheel] <= angle_reg[QB];
        end
    end

    assign done              = done_reg;
    assign front_left_speed  = spd_reg[sik_pkg::WHEEL_FL];
    assign rear_left_speed   = spd_reg[sik_pkg::WHEEL_RL];
    assign rear_right_speed  = spd_reg[sik_pkg::WHEEL_RR];
    assign front_right_speed = spd_reg[sik_pkg::WHEEL_FR];
    assign front_left_angle  = $signed(ang_reg[sik_pkg::WHEEL_FL]);
    assign rear_left_angle   = $signed(ang_reg[sik_pkg::WHEEL_RL]);
    assign rear_right_angle  = $signed(ang_reg[sik_pkg::WHEEL_RR]);
    assign front_right_angle = $signed(ang_reg[sik_pkg::WHEEL_FR]);

    `SIK_ASSERT_SAME(a_wheel_order, fin_valid && (fin_wheel != sik_pkg::WHEEL_FIRST),
        $past(fin_valid) && ($past(fin_wheel) == fin_wheel - 2'd1),
        "wheels left the pipeline out of order")
    `SIK_ASSERT_NEXT(a_issue_run, active_reg && (wheel_reg != sik_pkg::WHEEL_LAST),
        active_reg && (wheel_reg == $past(wheel_reg) + 2'd1),
        "wheel issue broke off inside a command")

endmodule

`default_nettype wire

[rtl/swerve_inverse_kinematics.sv]
// Channel   | Handshake                 | Word
// ----------+---------------------------+---------------------------------------
// command   | start high, busy low      | vel_fwd_mm_s, vel_left_mm_s, yaw_rate
// config    | cfg_wr_en high            | cfg_addr, cfg_data
// result    | done high for one cycle   | four wheel speeds and four angles
//
// Commands overlap: the four wheels of each share one
// pipelined CORDIC and one pipelined divider, one wheel entering per cycle.
// Commands pass front multipliers, queue, CORDIC and divider before done.
// busy rises when the 4-deep command queue plus the two front multiplier
// stages hold four commands; done cannot be held off by the receiver.
// Reset restores wheel radius 76 mm and center distance 300 mm.
`default_nettype none

module swerve_inverse_kinematics #(
    parameter int CORDIC_STEPS = sik_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [sik_pkg::VEL_W-1:0]     vel_fwd_mm_s,
    input  wire logic signed [sik_pkg::VEL_W-1:0]     vel_left_mm_s,
    input  wire logic signed [sik_pkg::YAW_W-1:0]     yaw_rate_mrad_s,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sik_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [sik_pkg::CFG_W-1:0]            cfg_data,
    output logic                                      done,
    output logic [sik_pkg::SPEED_W-1:0]               front_left_speed,
    output logic [sik_pkg::SPEED_W-1:0]               rear_left_speed,
    output logic [sik_pkg::SPEED_W-1:0]               rear_right_speed,
    output logic [sik_pkg::SPEED_W-1:0]               front_right_speed,
    output logic signed [sik_pkg::ANGLE_W-1:0]        front_left_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        rear_left_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        rear_right_angle,
    output logic signed [sik_pkg::ANGLE_W-1:0]        front_right_angle
);

    localparam int STEPS = (CORDIC_STEPS > sik_pkg::ATAN_ENTRIES)
                           ? sik_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int DEPTH = sik_pkg::QUEUE_DEPTH;
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [sik_pkg::RAD_W-1:0]  radius_reg;
    logic [sik_pkg::DIST_W-1:0] dist_reg;

    logic                       push, pop, q_empty;
    sik_pkg::cmd_t              push_cmd, q_cmd;
    logic [LVL_W-1:0]           q_level;

    // Write configuration registers, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= sik_pkg::RADIUS_RESET;
            dist_reg   <= sik_pkg::DIST_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                sik_pkg::REG_WHEEL_RADIUS: radius_reg <= cfg_data[sik_pkg::RAD_W-1:0];
                sik_pkg::REG_CENTER_DIST:  dist_reg   <= cfg_data[sik_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    sik_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .vel_fwd_mm_s       (vel_fwd_mm_s),
        .vel_left_mm_s      (vel_left_mm_s),
        .yaw_rate_mrad_s    (yaw_rate_mrad_s),
        .center_to_wheel_mm (dist_reg),
        .queue_level        (q_level),
        .push               (push),
        .cmd                (push_cmd)
    );

    sik_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (q_cmd),
        .empty (q_empty),
        .level (q_level)
    );

    sik_back #(
        .STEPS (STEPS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_cmd             (q_cmd),
        .q_pop             (pop),
        .wheel_radius_mm   (radius_reg),
        .done              (done),
        .front_left_speed  (front_left_speed),
        .rear_left_speed   (rear_left_speed),
        .rear_right_speed  (rear_right_speed),
        .front_right_speed (front_right_speed),
        .front_left_angle  (front_left_angle),
        .rear_left_angle   (rear_left_angle),
        .rear_right_angle  (rear_right_angle),
        .front_right_angle (front_right_angle)
    );

endmodule

`default_nettype wire
